// ===== hw/rtl/bpc_pkg.sv =====
// Shared types, constants and helper functions for the pressure compensation block
`timescale 1ns / 1ps
package bpc_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A_S = 3'd0,
    REG_COEF_A_U = 3'd1,
    REG_COEF_B   = 3'd2,
    REG_COEF_M   = 3'd3,
    REG_OSS      = 3'd4
  } bpc_reg_idx_t;

  // Divider geometry and sideband width
  localparam int DIV_W  = 32;
  localparam int SIDE_W = 53;

  // Formula constants
  localparam logic [31:0] C_B6_OFS = 32'd4000;
  localparam logic [31:0] C_P_K1   = 32'd3038;
  localparam logic [31:0] C_P_K2   = 32'hFFFF_E343; // -7357
  localparam logic [31:0] C_P_K3   = 32'd3791;
  localparam logic [31:0] C_B7_K   = 32'd50000;
  localparam logic [31:0] C_SIGN   = 32'h8000_0000;
  localparam logic [31:0] C_B4_OFS = 32'd32768;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [18:0] raw_pressure;
  } bpc_in_t;

  typedef struct packed {
    logic signed [27:0] temp_tenths;
    logic signed [31:0] pressure_pa;
    logic               div_error;
  } bpc_out_t;

  // Decoded calibration set, already widened to 32 bits
  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
    logic [1:0]  oss;
  } bpc_coef_t;

  // Queue status towards the front
  typedef struct packed {
    logic full;
    logic empty;
  } bpc_q_stat_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    logic signed [31:0] sv;
    sv = $signed(v);
    return 32'(sv >>> s);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ===== hw/rtl/barometric_pressure_compensation.sv =====
// Top level of the barometric pressure and temperature compensation block
//
// One request (raw temperature and raw pressure word) may be issued with start in
// every clock cycle; busy stays low in normal use since the back end never stalls.
// Each request gives one result on out_res, flagged by out_strobe for one cycle,
// in request order; results must be taken as they come.
// The data path runs through the two 32-stage divider pipelines (temperature and
// pressure) plus the arithmetic stages around them. The user must write the
// calibration and oversampling registers through cfg_we/cfg_index/cfg_data only
// while no request is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  bpc_in_t               in_req,
  output logic                  out_strobe,
  output bpc_out_t              out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bpc_q_stat_t q_stat;
  bpc_coef_t   coef;
  bpc_in_t     push_item, pop_item;
  logic        push, pop, pop_v;

  bpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .push_item (push_item),
    .coef      (coef)
  );

  bpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_v     (pop_v),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  bpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_v      (pop_v),
    .pop_item   (pop_item),
    .coef       (coef),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

// ===== hw/rtl/bpc_front.sv =====
// Front end: configuration registers, coefficient decode and request capture
`timescale 1ns / 1ps
module bpc_front
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  bpc_in_t               in_req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  bpc_q_stat_t           q_stat,
  output logic                  busy,
  output logic                  push,
  output bpc_in_t               push_item,
  output bpc_coef_t             coef
);

  logic [47:0] coef_a_s_r, coef_a_u_r;
  logic [31:0] coef_b_r, coef_m_r;
  logic [1:0]  oss_r;
  logic        cap_v_r;
  bpc_in_t     cap_item_r;

  // Write calibration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_s_r <= '0;
      coef_a_u_r <= '0;
      coef_b_r   <= '0;
      coef_m_r   <= '0;
      oss_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_A_S: coef_a_s_r <= cfg_data;
        REG_COEF_A_U: coef_a_u_r <= cfg_data;
        REG_COEF_B:   coef_b_r   <= cfg_data[31:0];
        REG_COEF_M:   coef_m_r   <= cfg_data[31:0];
        REG_OSS:      oss_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Hold off new requests only while the queue is full
  assign busy = q_stat.full;

  // Capture the accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_v_r <= 1'b0;
    end else begin
      cap_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cap_item_r <= in_req;
    end
  end

  assign push      = cap_v_r;
  assign push_item = cap_item_r;

  // Decode the packed coefficient fields
  always_comb begin
    coef.ac1 = sext16(coef_a_s_r[47:32]);
    coef.ac2 = sext16(coef_a_s_r[31:16]);
    coef.ac3 = sext16(coef_a_s_r[15:0]);
    coef.ac4 = {16'b0, coef_a_u_r[47:32]};
    coef.ac5 = {16'b0, coef_a_u_r[31:16]};
    coef.ac6 = {16'b0, coef_a_u_r[15:0]};
    coef.b1  = sext16(coef_b_r[31:16]);
    coef.b2  = sext16(coef_b_r[15:0]);
    coef.mc  = sext16(coef_m_r[31:16]);
    coef.md  = sext16(coef_m_r[15:0]);
    coef.oss = oss_r;
  end

endmodule

// ===== hw/rtl/bpc_queue.sv =====
// Two-entry request queue between front and back
`timescale 1ns / 1ps
module bpc_queue
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  bpc_in_t     push_item,
  input  logic        pop,
  output logic        pop_v,
  output bpc_in_t     pop_item,
  output bpc_q_stat_t q_stat
);

  bpc_in_t    mem_r [0:1];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign do_pop       = pop && (cnt_r != 2'd0);
  assign pop_v        = cnt_r != 2'd0;
  assign pop_item     = mem_r[rd_r];
  assign q_stat.full  = cnt_r == 2'd2;
  assign q_stat.empty = cnt_r == 2'd0;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (do_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !(push && !do_pop))
    else $error("request queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("request queue count out of range");
  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && cnt_r == 2'd1 && !push) |=> q_stat.empty)
    else $error("request queue failed to drain");

endmodule

// ===== hw/rtl/bpc_udiv.sv =====
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module bpc_udiv
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  input  logic [DIV_W-1:0]  num,
  input  logic [DIV_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_v,
  output logic [DIV_W-1:0]  quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              v_r    [0:DIV_W-1];
  logic [DIV_W-1:0]  rem_r  [0:DIV_W-1];
  logic [DIV_W-1:0]  nq_r   [0:DIV_W-1];
  logic [DIV_W-1:0]  den_r  [0:DIV_W-1];
  logic [SIDE_W-1:0] side_r [0:DIV_W-1];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic              src_v;
    logic [DIV_W-1:0]  src_rem, src_nq, src_den;
    logic [SIDE_W-1:0] src_side;
    logic [DIV_W:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_v    = in_v;
      assign src_rem  = '0;
      assign src_nq   = num;
      assign src_den  = den;
      assign src_side = side;
    end else begin : g_next
      assign src_v    = v_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_nq   = nq_r[k-1];
      assign src_den  = den_r[k-1];
      assign src_side = side_r[k-1];
    end

    // Shift in the next numerator bit and try the subtract
    assign trial = {src_rem, src_nq[DIV_W-1]};
    assign ge    = trial >= {1'b0, src_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? DIV_W'(trial - {1'b0, src_den}) : trial[DIV_W-1:0];
      nq_r[k]   <= {src_nq[DIV_W-2:0], ge};
      den_r[k]  <= src_den;
      side_r[k] <= src_side;
    end
  end

  assign out_v    = v_r[DIV_W-1];
  assign quo      = nq_r[DIV_W-1];
  assign out_side = side_r[DIV_W-1];

endmodule

// ===== hw/rtl/bpc_back.sv =====
// Back end: compensation arithmetic pipeline with two divider passes
`timescale 1ns / 1ps
module bpc_back
  import bpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pop_v,
  input  bpc_in_t   pop_item,
  input  bpc_coef_t coef,
  output logic      pop,
  output logic      out_strobe,
  output bpc_out_t  out_res
);

  localparam int PAD2 = SIDE_W - 30;

  // The back never stalls: take every queued request at once
  assign pop = pop_v;

  // Stage 1: temperature product
  logic        s1_v_r;
  logic [31:0] s1_prod_r;
  logic [18:0] s1_up_r;
  // Stage 2: first temperature term and divisor
  logic        s2_v_r;
  logic [31:0] s2_x1_r, s2_d_r;
  logic [18:0] s2_up_r;
  // Stage 3: B5 and temperature
  logic        s3_v_r, s3_err_r;
  logic [31:0] s3_b5_r;
  logic [27:0] s3_temp_r;
  logic [18:0] s3_up_r;
  // Stage 4: B6 and its square
  logic        s4_v_r, s4_err_r;
  logic [31:0] s4_b6_r, s4_sqp_r;
  logic [27:0] s4_temp_r;
  logic [18:0] s4_up_r;
  // Stage 5: four coefficient products
  logic        s5_v_r, s5_err_r;
  logic [31:0] s5_m1_r, s5_m2_r, s5_m3_r, s5_m4_r;
  logic [27:0] s5_temp_r;
  logic [18:0] s5_up_r;
  // Stage 6: B3 and B4 multiplicand
  logic        s6_v_r, s6_err_r;
  logic [31:0] s6_b3_r, s6_c_r;
  logic [27:0] s6_temp_r;
  logic [18:0] s6_up_r;
  // Stage 7: B4 product and pressure offset
  logic        s7_v_r, s7_err_r;
  logic [31:0] s7_b4p_r, s7_upb_r;
  logic [27:0] s7_temp_r;
  // Stage 8: B4 and B7
  logic        s8_v_r, s8_err_r;
  logic [31:0] s8_b4_r, s8_b7_r;
  logic [27:0] s8_temp_r;
  // Stage 9..11: pressure correction
  logic        s9_v_r, s9_err_r;
  logic [31:0] s9_p_r, s9_pp_r, s9_mp_r;
  logic [27:0] s9_temp_r;
  logic        s10_v_r, s10_err_r;
  logic [31:0] s10_p_r, s10_m_r, s10_x2_r;
  logic [27:0] s10_temp_r;
  logic        out_v_r;
  bpc_out_t    out_r;

  // Divider links
  logic              d1_in_v, d1_out_v, d2_in_v, d2_out_v;
  logic [31:0]       d1_num, d1_den, d1_quo, d2_num, d2_quo;
  logic [SIDE_W-1:0] d1_side, d1_oside, d2_side, d2_oside;
  logic              d1_neg, d2_big;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= pop_v;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= d1_out_v;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= d2_out_v;
      s10_v_r <= s9_v_r;
      out_v_r <= s10_v_r;
    end
  end

  // Stage 1 and 2: UT term and divisor X1 + MD
  always_ff @(posedge clk) begin
    s1_prod_r <= 32'(({16'b0, pop_item.raw_temp} - coef.ac6) * coef.ac5);
    s1_up_r   <= pop_item.raw_pressure;
    s2_x1_r   <= asr32(s1_prod_r, 5'd15);
    s2_d_r    <= asr32(s1_prod_r, 5'd15) + coef.md;
    s2_up_r   <= s1_up_r;
  end

  // Signed divide MC << 11 by X1 + MD through magnitudes
  logic [31:0] mc_sh;
  assign mc_sh   = {coef.mc[20:0], 11'b0};
  assign d1_neg  = mc_sh[31] ^ s2_d_r[31];
  assign d1_in_v = s2_v_r;
  assign d1_num  = mc_sh[31] ? 32'(0 - mc_sh) : mc_sh;
  assign d1_den  = s2_d_r[31] ? 32'(0 - s2_d_r) : s2_d_r;
  assign d1_side = {s2_up_r, s2_x1_r, d1_neg, s2_d_r == 32'd0};

  bpc_udiv u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (d1_in_v),
    .num      (d1_num),
    .den      (d1_den),
    .side     (d1_side),
    .out_v    (d1_out_v),
    .quo      (d1_quo),
    .out_side (d1_oside)
  );

  // Stage 3: B5 and temperature
  logic [31:0] b5_c, temp_c;
  assign b5_c   = d1_oside[33:2] + (d1_oside[1] ? 32'(0 - d1_quo) : d1_quo);
  assign temp_c = asr32(b5_c + 32'd8, 5'd4);

  always_ff @(posedge clk) begin
    s3_b5_r   <= b5_c;
    s3_temp_r <= temp_c[27:0];
    s3_err_r  <= d1_oside[0];
    s3_up_r   <= d1_oside[52:34];
  end

  // Stage 4..6: pressure coefficient terms
  logic [31:0] sq_c, x3_c, b3v_c, x3b_c;
  assign sq_c  = asr32(s4_sqp_r, 5'd12);
  assign x3_c  = asr32(s5_m1_r, 5'd11) + asr32(s5_m2_r, 5'd11);
  assign b3v_c = 32'(((coef.ac1 << 2) + x3_c) << coef.oss) + 32'd2;
  assign x3b_c = asr32(asr32(s5_m3_r, 5'd13) + asr32(s5_m4_r, 5'd16) + 32'd2, 5'd2);

  always_ff @(posedge clk) begin
    s4_b6_r   <= s3_b5_r - C_B6_OFS;
    s4_sqp_r  <= 32'((s3_b5_r - C_B6_OFS) * (s3_b5_r - C_B6_OFS));
    s4_temp_r <= s3_temp_r;
    s4_err_r  <= s3_err_r;
    s4_up_r   <= s3_up_r;

    s5_m1_r   <= 32'(coef.b2 * sq_c);
    s5_m2_r   <= 32'(coef.ac2 * s4_b6_r);
    s5_m3_r   <= 32'(coef.ac3 * s4_b6_r);
    s5_m4_r   <= 32'(coef.b1 * sq_c);
    s5_temp_r <= s4_temp_r;
    s5_err_r  <= s4_err_r;
    s5_up_r   <= s4_up_r;

    // Divide by four truncating towards zero
    s6_b3_r   <= b3v_c[31] ? asr32(b3v_c + 32'd3, 5'd2) : asr32(b3v_c, 5'd2);
    s6_c_r    <= x3b_c + C_B4_OFS;
    s6_temp_r <= s5_temp_r;
    s6_err_r  <= s5_err_r;
    s6_up_r   <= s5_up_r;

    s7_b4p_r  <= 32'(coef.ac4 * s6_c_r);
    s7_upb_r  <= {13'b0, s6_up_r} - s6_b3_r;
    s7_temp_r <= s6_temp_r;
    s7_err_r  <= s6_err_r;

    s8_b4_r   <= s7_b4p_r >> 15;
    s8_b7_r   <= 32'(s7_upb_r * (C_B7_K >> coef.oss));
    s8_temp_r <= s7_temp_r;
    s8_err_r  <= s7_err_r || (s7_b4p_r[31:15] == 17'd0);
  end

  // Pressure division: shift before or after depending on the top bit of B7
  assign d2_big  = s8_b7_r >= C_SIGN;
  assign d2_in_v = s8_v_r;
  assign d2_num  = d2_big ? s8_b7_r : {s8_b7_r[30:0], 1'b0};
  assign d2_side = {{PAD2{1'b0}}, d2_big, s8_err_r, s8_temp_r};

  bpc_udiv u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (d2_in_v),
    .num      (d2_num),
    .den      (s8_b4_r),
    .side     (d2_side),
    .out_v    (d2_out_v),
    .quo      (d2_quo),
    .out_side (d2_oside)
  );

  // Stage 9..11: final correction of pressure
  logic [31:0] p_c, r_c, pf_c;
  assign p_c  = d2_oside[29] ? {d2_quo[30:0], 1'b0} : d2_quo;
  assign r_c  = asr32(p_c, 5'd8);
  assign pf_c = s10_p_r + asr32(asr32(s10_m_r, 5'd16) + s10_x2_r + C_P_K3, 5'd4);

  always_ff @(posedge clk) begin
    s9_p_r     <= p_c;
    s9_pp_r    <= 32'(r_c * r_c);
    s9_mp_r    <= 32'(C_P_K2 * p_c);
    s9_temp_r  <= d2_oside[27:0];
    s9_err_r   <= d2_oside[28];

    s10_p_r    <= s9_p_r;
    s10_m_r    <= 32'(s9_pp_r * C_P_K1);
    s10_x2_r   <= asr32(s9_mp_r, 5'd16);
    s10_temp_r <= s9_temp_r;
    s10_err_r  <= s9_err_r;

    // Force zero results on a zero divisor
    out_r.temp_tenths <= s10_err_r ? '0 : $signed(s10_temp_r);
    out_r.pressure_pa <= s10_err_r ? '0 : $signed(pf_c);
    out_r.div_error   <= s10_err_r;
  end

  assign out_strobe = out_v_r;
  assign out_res    = out_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.div_error) |-> (out_res.temp_tenths == '0 &&
                                           out_res.pressure_pa == '0))
    else $error("error result carries non-zero fields");
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s10_v_r |=> out_strobe)
    else $error("pipeline lost a request");
  a_div_lat: assert property (@(posedge clk) disable iff (!rst_n)
    d1_out_v |-> ##6 d2_in_v)
    else $error("stages between dividers out of step");

endmodule

// ===== tb/barometric_pressure_compensation_test.sv =====
// Self-checking testbench for the barometric pressure compensation block
`timescale 1ns / 1ps
module barometric_pressure_compensation_test;
  import bpc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  bpc_in_t               in_req;
  logic                  out_strobe;
  bpc_out_t              out_res;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  localparam int LATENCY = 77;

  // Calibration copy held by the testbench
  logic [47:0] cal_a_s, cal_a_u;
  logic [31:0] cal_b, cal_m;
  logic [1:0]  cal_oss;

  bpc_out_t pending_q[$];
  int       fail_count;

  barometric_pressure_compensation u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [31:0] sra(input logic [31:0] v, input int s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] wide16s(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Truncating signed divide on 32-bit words, wrapping the one overflow case
  function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Compensate one raw pair with the current calibration
  function automatic bpc_out_t compensate(input bpc_in_t r);
    bpc_out_t    o;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, d, b5, b6, sq, b3, b4, b7, p, t;
    ac1 = wide16s(cal_a_s[47:32]);
    ac2 = wide16s(cal_a_s[31:16]);
    ac3 = wide16s(cal_a_s[15:0]);
    ac4 = {16'd0, cal_a_u[47:32]};
    ac5 = {16'd0, cal_a_u[31:16]};
    ac6 = {16'd0, cal_a_u[15:0]};
    b1  = wide16s(cal_b[31:16]);
    b2  = wide16s(cal_b[15:0]);
    mc  = wide16s(cal_m[31:16]);
    md  = wide16s(cal_m[15:0]);
    ut  = {16'd0, r.raw_temp};
    up  = {13'd0, r.raw_pressure};
    o   = '0;
    x1 = sra((ut - ac6) * ac5, 15);
    d  = x1 + md;
    if (d == 0) begin
      o.div_error = 1'b1;
      return o;
    end
    x2 = (d == 32'hFFFF_FFFF && (mc << 11) == 32'h8000_0000) ? 32'h8000_0000
                                                              : div_trunc(mc << 11, d);
    b5 = x1 + x2;
    t  = sra(b5 + 32'd8, 4);
    b6 = b5 - 32'd4000;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = div_trunc(((ac1 * 32'd4 + x3) << cal_oss) + 32'd2, 32'd4);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) begin
      o.div_error = 1'b1;
      return o;
    end
    b7 = (up - b3) * (32'd50000 >> cal_oss);
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * 32'd3038, 16);
    x2 = sra(-32'd7357 * p, 16);
    p  = p + sra(x1 + x2 + 32'd3791, 4);
    o.temp_tenths = t[27:0];
    o.pressure_pa = p;
    return o;
  endfunction

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    bpc_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result got %h", $time, out_res);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (out_res.temp_tenths !== want.temp_tenths) begin
          $display("%0t: temp_tenths expected %0d got %0d", $time,
                   want.temp_tenths, out_res.temp_tenths);
          fail_count++;
        end
        if (out_res.pressure_pa !== want.pressure_pa) begin
          $display("%0t: pressure_pa expected %0d got %0d", $time,
                   want.pressure_pa, out_res.pressure_pa);
          fail_count++;
        end
        if (out_res.div_error !== want.div_error) begin
          $display("%0t: div_error expected %0b got %0b", $time,
                   want.div_error, out_res.div_error);
          fail_count++;
        end
      end
    end
  end

  // Wait for the pipeline to drain, then hold a little longer
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write one register; the caller drops the write enable after the last one
  task automatic write_reg(input bpc_reg_idx_t idx, input logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_COEF_A_S: cal_a_s = val;
      REG_COEF_A_U: cal_a_u = val;
      REG_COEF_B:   cal_b   = val[31:0];
      REG_COEF_M:   cal_m   = val[31:0];
      REG_OSS:      cal_oss = val[1:0];
      default: ;
    endcase
  endtask

  task automatic load_cal(input logic [47:0] a_s, input logic [47:0] a_u,
                          input logic [31:0] b, input logic [31:0] m,
                          input logic [1:0] oss);
    drain();
    write_reg(REG_COEF_A_S, a_s);
    write_reg(REG_COEF_A_U, a_u);
    write_reg(REG_COEF_B, {16'd0, b});
    write_reg(REG_COEF_M, {16'd0, m});
    write_reg(REG_OSS, {46'd0, oss});
    cfg_we <= 1'b0;
  endtask

  // Issue one request; start stays high when another follows
  task automatic send_request(input logic [15:0] ut, input logic [18:0] up, input bit more);
    bpc_in_t r;
    r.raw_temp     = ut;
    r.raw_pressure = up;
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(compensate(r));
    if (!more) start <= 1'b0;
  endtask

  // Random bursts, most of them followed by a gap
  task automatic random_burst_run(input int count);
    int burst, gap, i;
    i = 0;
    while (i < count) begin
      burst = $urandom_range(1, 40);
      gap   = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
      for (int k = 0; k < burst && i < count; k++) begin
        send_request(16'($urandom_range(0, 65535)), 19'($urandom_range(0, 524287)),
                     ((k != burst - 1) || (gap == 0)) && (i != count - 1));
        i++;
      end
      if (gap != 0) repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_reset_cal();
    // All-zero calibration gives a zero divisor on every request
    send_request(16'd0, 19'd0, 1'b1);
    send_request(16'hFFFF, 19'h7FFFF, 1'b0);
  endtask

  task automatic test_datasheet_example();
    // ac1 408, ac2 -72, ac3 -14383, ac4 32741, ac5 32757, ac6 23153, b1 6190,
    // b2 4, mc -8711, md 2868
    load_cal({16'd408, 16'hFFB8, 16'hC7D1}, {16'd32741, 16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {16'hDDF9, 16'd2868}, 2'd0);
    send_request(16'd27898, 19'd23843, 1'b1);
    send_request(16'd0, 19'd0, 1'b1);
    send_request(16'hFFFF, 19'h7FFFF, 1'b1);
    send_request(16'h5555, 19'h2AAAA, 1'b1);
    send_request(16'hAAAA, 19'h55555, 1'b0);
    // Sender pauses until every result is in
    drain();
    send_request(16'd23153, 19'd40000, 1'b0);
  endtask

  task automatic test_zero_divisors();
    // ac5 zero with md zero: first divisor is zero
    load_cal(48'h0001_0002_0003, {16'd100, 16'd0, 16'd0}, 32'h0001_0001, 32'h0004_0000, 2'd1);
    send_request(16'd1234, 19'd5000, 1'b0);
    // ac4 zero: second divisor is zero
    load_cal(48'h0198_FFB8_C7D1, {16'd0, 16'd32757, 16'd23153}, 32'h182E_0004,
             32'hDDF9_0B34, 2'd2);
    send_request(16'd27898, 19'd23843, 1'b0);
    // mc most negative and divisor -1
    load_cal(48'h0198_FFB8_C7D1, {16'd32741, 16'd0, 16'd0}, 32'h182E_0004,
             32'h8000_FFFF, 2'd3);
    send_request(16'd7, 19'h7FFFF, 1'b0);
  endtask

  task automatic test_random_cal();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7)
        load_cal(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
      else if (ph % 2 == 0)
        // Realistic calibration with jitter
        load_cal({16'(408 + $urandom_range(0, 200)), 16'hFFB8, 16'hC7D1},
                 {16'(32741 - $urandom_range(0, 500)), 16'd32757,
                  16'(23153 + $urandom_range(0, 300))},
                 {16'd6190, 16'($urandom_range(0, 8))},
                 {16'hDDF9, 16'(2868 + $urandom_range(0, 50))},
                 2'($urandom_range(0, 3)));
      else
        load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom, $urandom,
                 2'($urandom_range(0, 3)));
      random_burst_run(235);
    end
  endtask

  initial begin
    fail_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cal_a_s = '0;
    cal_a_u = '0;
    cal_b = '0;
    cal_m = '0;
    cal_oss = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_cal();
    test_datasheet_example();
    test_zero_divisors();
    test_random_cal();
    drain();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
